[hw/rtl/ospq_pkg.sv]
// Package for the one-sided quadratic penalty block: widths, register indexes,
// quantity codes and the controller-to-datapath command and status types.
// No dependencies.
package ospq_pkg;

  localparam int unsigned DefMaxItems = 65536;
  localparam int unsigned DefFracBits = 8;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ValueW  = 48;
  localparam int unsigned CountW  = 17;
  localparam int unsigned SumW    = 64;
  localparam int unsigned TermW   = 33;
  localparam int unsigned FactorW = 17;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned PpW     = HalfW + FactorW;
  localparam int unsigned ProdW   = SumW + FactorW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 3 * SampleW;
  localparam int unsigned OutDataW = ((ValueW + CountW + 7) / 8) * 8;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWeight    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLimitSide = 2'd2;
  localparam logic [CfgIdxW-1:0] RegQuantity  = 2'd3;

  localparam logic [1:0] QtyCost = 2'd0;
  localparam logic [1:0] QtyGrad = 2'd1;

  localparam logic [SampleW-1:0] WeightReset = 16'd256;

  typedef struct packed {
    logic capture;     // take the accepted beat's term
    logic accumulate;  // add the held term into the sum
    logic absval;      // split the sum into sign and magnitude
    logic mul_lo;      // low partial product of the scaling
    logic mul_hi;      // high partial product
    logic scale;       // combine, rescale, load the divider
    logic div_step;    // one quotient bit
    logic finish;      // load the output register, clear the set
  } cmd_t;

  typedef struct packed {
    logic last;        // held term closes the set
    logic div_last;    // final quotient bit in this cycle
    logic out_free;    // output register can take a result
  } status_t;

endpackage

[hw/rtl/ospq_ctrl.sv]
// Sequencer of the penalty block: accepts beats, then runs scaling,
// division and result hand-off. Depends on ospq_pkg.
module ospq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ospq_pkg::status_t status_i,
  output ospq_pkg::cmd_t   cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ACC    = 8'b0000_0010,
    S_ABS    = 8'b0000_0100,
    S_MUL_LO = 8'b0000_1000,
    S_MUL_HI = 8'b0001_0000,
    S_SCALE  = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // a new beat may overlap the accumulation of the previous one
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_ACC) && !status_i.last);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.capture = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.accumulate = 1'b1;
        if (status_i.last) state_d = S_ABS;
        else if (accept)   state_d = S_ACC;
        else               state_d = S_IDLE;
      end
      S_ABS: begin
        cmd_o.absval = 1'b1;
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/ospq_dp.sv]
// Datapath of the penalty block: configuration registers, per-beat term,
// running sum, split scaling multiply, restoring divider, output register.
// Depends on ospq_pkg.
module ospq_dp #(
  parameter int unsigned MAX_ITEMS = ospq_pkg::DefMaxItems,
  parameter int unsigned FRAC_BITS = ospq_pkg::DefFracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ospq_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ospq_pkg::SampleW-1:0]        cfg_wdata_i,
  input  logic [ospq_pkg::SampleW-1:0]        dose_i,
  input  logic [ospq_pkg::SampleW-1:0]        coeff_one_i,
  input  logic [ospq_pkg::SampleW-1:0]        coeff_two_i,
  input  logic                                last_i,
  input  ospq_pkg::cmd_t                      cmd_i,
  output ospq_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ospq_pkg::ValueW-1:0]  value_o,
  output logic                                saturated_o,
  output logic [ospq_pkg::CountW-1:0]         item_count_o
);

  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam int          Shift = 3 * int'(FRAC_BITS) - 16;
  localparam int unsigned LSh   = (Shift < 0) ? -Shift : 0;
  localparam int unsigned RSh   = (Shift > 0) ? Shift : 0;
  localparam int unsigned DivW  = ospq_pkg::ProdW + LSh;
  localparam int unsigned DcW   = $clog2(DivW);
  localparam int unsigned SW    = ospq_pkg::SampleW;
  localparam int unsigned VW    = ospq_pkg::ValueW;

  localparam logic [DivW-1:0] PosLimit = DivW'({1'b0, {(VW-1){1'b1}}});
  localparam logic [DivW-1:0] NegLimit = DivW'({1'b1, {(VW-1){1'b0}}});

  // configuration
  logic [SW-1:0] threshold_q, weight_q;
  logic          side_q;
  logic [1:0]    quantity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      weight_q    <= ospq_pkg::WeightReset;
      side_q      <= 1'b0;
      quantity_q  <= ospq_pkg::QtyCost;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ospq_pkg::RegThreshold: threshold_q <= cfg_wdata_i;
        ospq_pkg::RegWeight:    weight_q    <= cfg_wdata_i;
        ospq_pkg::RegLimitSide: side_q      <= cfg_wdata_i[0];
        ospq_pkg::RegQuantity:  quantity_q  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // per-beat term
  logic                            below, above, active, negate;
  logic [SW-1:0]                   diff, op_a, op_b;
  logic [2*SW-1:0]                 prod16;
  logic signed [ospq_pkg::TermW-1:0] term_d;
  logic signed [ospq_pkg::TermW-1:0] term_q;
  logic                            last_q;

  always_comb begin
    below  = dose_i < threshold_q;
    above  = dose_i > threshold_q;
    diff   = below ? (threshold_q - dose_i) : (dose_i - threshold_q);
    negate = 1'b0;
    unique case (quantity_q)
      ospq_pkg::QtyCost: begin
        op_a = diff; op_b = diff;
        active = side_q ? above : below;
      end
      ospq_pkg::QtyGrad: begin
        op_a = diff; op_b = coeff_one_i;
        active = side_q ? above : below;
        negate = !side_q;
      end
      default: begin
        // Hessian term, inclusive comparison
        op_a = coeff_one_i; op_b = coeff_two_i;
        active = side_q ? !below : !above;
      end
    endcase
    prod16 = op_a * op_b;
    if (!active)     term_d = '0;
    else if (negate) term_d = -$signed({1'b0, prod16});
    else             term_d = $signed({1'b0, prod16});
  end

  // running sum and count
  logic [ospq_pkg::SumW-1:0] sum_q;
  logic [CntW-1:0]           count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= 1'b0;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.capture) last_q <= last_i;
      if (cmd_i.finish) begin
        sum_q   <= '0;
        count_q <= '0;
      end else if (cmd_i.accumulate && (count_q < CntW'(MAX_ITEMS))) begin
        sum_q   <= sum_q + ospq_pkg::SumW'(term_q);
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) term_q <= term_d;
  end

  // scaling: magnitude times weight (doubled for gradient and Hessian)
  logic                         neg_q;
  logic [ospq_pkg::SumW-1:0]    mag_q;
  logic [ospq_pkg::FactorW-1:0] factor;
  logic [ospq_pkg::HalfW-1:0]   half;
  logic [ospq_pkg::PpW-1:0]     pp, pp0_q, pp1_q;
  logic [ospq_pkg::ProdW-1:0]   prod;

  assign factor = (quantity_q == ospq_pkg::QtyCost) ? {1'b0, weight_q} : {weight_q, 1'b0};
  assign half   = cmd_i.mul_hi ? mag_q[ospq_pkg::SumW-1:ospq_pkg::HalfW]
                               : mag_q[ospq_pkg::HalfW-1:0];
  assign pp     = half * factor;
  assign prod   = (ospq_pkg::ProdW'(pp1_q) << ospq_pkg::HalfW) + ospq_pkg::ProdW'(pp0_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.absval) begin
      neg_q <= sum_q[ospq_pkg::SumW-1];
      mag_q <= sum_q[ospq_pkg::SumW-1] ? (~sum_q + 1'b1) : sum_q;
    end
    if (cmd_i.mul_lo) pp0_q <= pp;
    if (cmd_i.mul_hi) pp1_q <= pp;
  end

  // restoring division by the item count, one quotient bit a cycle
  logic [DivW-1:0] quo_q;
  logic [CntW-1:0] rem_q;
  logic [DcW-1:0]  div_cnt_q;
  logic [CntW:0]   trial;
  logic            fits;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      quo_q     <= (DivW'(prod) << LSh) >> RSh;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q     <= {quo_q[DivW-2:0], fits};
      rem_q     <= fits ? CntW'(trial - {1'b0, count_q}) : trial[CntW-1:0];
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // clamp and output register
  logic                 sat;
  logic [VW-1:0]        clamp_mag;
  logic                 out_valid_q;
  logic [VW-1:0]        value_q;
  logic                 sat_q;
  logic [ospq_pkg::CountW-1:0] count_out_q;

  always_comb begin
    if (neg_q) begin
      sat       = quo_q > NegLimit;
      clamp_mag = sat ? NegLimit[VW-1:0] : quo_q[VW-1:0];
    end else begin
      sat       = quo_q > PosLimit;
      clamp_mag = sat ? PosLimit[VW-1:0] : quo_q[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      value_q     <= neg_q ? (~clamp_mag + 1'b1) : clamp_mag;
      sat_q       <= sat;
      count_out_q <= ospq_pkg::CountW'(count_q);
    end
  end

  assign status_o.last     = last_q;
  assign status_o.div_last = div_cnt_q == DcW'(DivW - 1);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign value_o      = $signed(value_q);
  assign saturated_o  = sat_q;
  assign item_count_o = count_out_q;

endmodule

[hw/rtl/one_sided_quadratic_penalty.sv]
// Top level of the one-sided quadratic penalty accumulator.
// Depends on ospq_pkg, ospq_ctrl and ospq_dp.
//
// Input stream: one beat per voxel; tdata carries dose, coeff_one and
// coeff_two (Q8.8), tlast closes the data set. Beats of a set are taken one
// per cycle: the term of a beat is formed on acceptance and added to the
// 64-bit sum in the next cycle while the next beat is taken.
// Configuration: cfg_we_i writes threshold, weight, limit_side or quantity
// by index; write only while the block is idle.
// After the beat marked last the block scales the sum by the weight
// (two 32x17 partial products), rescales it and divides it by the item count
// with a restoring divider giving one quotient bit a cycle. No beats are taken
// until the result has been loaded into the output register.
// Output stream: one beat per set; tdata holds value (signed Q32.16) and
// item_count, tuser flags saturation. The result waits in an output register,
// so the next set streams in while it is not yet taken; a set only stalls in
// its final step if the previous result is still held.
// Reset clears the sum, count, sequencer and output valid, and sets the
// registers to threshold 0, weight 1.0, lower limit, cost.
module one_sided_quadratic_penalty #(
  parameter int unsigned MAX_ITEMS = ospq_pkg::DefMaxItems,
  parameter int unsigned FRAC_BITS = ospq_pkg::DefFracBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ospq_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ospq_pkg::SampleW-1:0]         cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // dose [15:0], coeff_one [31:16], coeff_two [47:32]
  input  logic [ospq_pkg::InDataW-1:0]         s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // value [47:0], item_count [64:48], zero fill [71:65]
  output logic [ospq_pkg::OutDataW-1:0]        m_axis_tdata,
  // saturated [0]
  output logic                                 m_axis_tuser
);

  localparam int unsigned SW = ospq_pkg::SampleW;

  ospq_pkg::cmd_t    cmd;
  ospq_pkg::status_t status;

  logic signed [ospq_pkg::ValueW-1:0] value;
  logic [ospq_pkg::CountW-1:0]        item_count;

  ospq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ospq_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .dose_i       (s_axis_tdata[SW-1:0]),
    .coeff_one_i  (s_axis_tdata[2*SW-1:SW]),
    .coeff_two_i  (s_axis_tdata[3*SW-1:2*SW]),
    .last_i       (s_axis_tlast),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .value_o      (value),
    .saturated_o  (m_axis_tuser),
    .item_count_o (item_count)
  );

  assign m_axis_tdata = ospq_pkg::OutDataW'({item_count, value});

endmodule

[tb/sv/tb_one_sided_quadratic_penalty.sv]
// Self-checking testbench for one_sided_quadratic_penalty: streams voxel sets, predicts each
// scaled penalty beat and compares it field by field with the block's output stream.
// Depends on ospq_pkg and the one_sided_quadratic_penalty RTL.
`timescale 1ns / 1ps

module tb_one_sided_quadratic_penalty;
  import ospq_pkg::*;

  localparam logic [1:0] QtyHess  = 2'd2;
  localparam logic [1:0] QtySpare = 2'd3;    // unused code, behaves as Hessian
  localparam int unsigned Rescale    = 3 * DefFracBits - 16;
  localparam int unsigned DrainWait  = 200;  // covers the final scaling and divide
  localparam int unsigned LongHold   = 3000;
  localparam int unsigned SpareSet   = 8;
  localparam logic [127:0] PosLimit  = 128'h7FFF_FFFF_FFFF;
  localparam logic [127:0] NegLimit  = 128'h8000_0000_0000;

  typedef struct {
    logic [SampleW-1:0] dose;
    logic [SampleW-1:0] coeff_one;
    logic [SampleW-1:0] coeff_two;
    logic               last;
  } voxel_t;

  typedef struct {
    logic [ValueW-1:0] value;
    logic              sat;
    logic [CountW-1:0] count;
  } penalty_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [SampleW-1:0]    cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tuser;

  voxel_t   voxel_q[$];
  penalty_t expected_penalty_q[$];
  int unsigned voxels_queued = 0;
  int unsigned voxels_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // shadow of the block's registers and running set
  logic [SampleW-1:0] thr_q = '0;
  logic [SampleW-1:0] weight_q = WeightReset;
  logic               upper_q = 1'b0;
  logic [1:0]         qty_q = QtyCost;
  logic [SumW-1:0]    acc_sum = '0;
  int unsigned        acc_count = 0;

  one_sided_quadratic_penalty dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [SumW-1:0] voxel_term(voxel_t v);
    logic [SumW-1:0] d;
    logic [SumW-1:0] t;
    logic [SumW-1:0] c1;
    logic [SumW-1:0] c2;
    d  = {48'd0, v.dose};
    t  = {48'd0, thr_q};
    c1 = {48'd0, v.coeff_one};
    c2 = {48'd0, v.coeff_two};
    voxel_term = '0;
    case (qty_q)
      QtyCost: begin
        if (!upper_q && d < t) voxel_term = (t - d) * (t - d);
        else if (upper_q && d > t) voxel_term = (d - t) * (d - t);
      end
      QtyGrad: begin
        if (!upper_q && d < t) voxel_term = -((t - d) * c1);
        else if (upper_q && d > t) voxel_term = (d - t) * c1;
      end
      default: begin
        // Hessian: threshold itself is inside the penalised region
        if ((!upper_q && d <= t) || (upper_q && d >= t)) voxel_term = c1 * c2;
      end
    endcase
  endfunction

  function automatic penalty_t scaled_penalty(logic [SumW-1:0] sum, int unsigned cnt);
    penalty_t        r;
    logic            neg;
    logic [SumW-1:0] mag;
    logic [17:0]     factor;
    logic [127:0]    wide;
    neg    = sum[SumW-1];
    mag    = neg ? -sum : sum;
    factor = (qty_q == QtyCost) ? {2'b00, weight_q} : {1'b0, weight_q, 1'b0};
    wide   = {64'd0, mag};
    wide   = (wide * factor) >> Rescale;
    wide   = wide / cnt;
    r.sat  = 1'b0;
    if (neg) begin
      if (wide > NegLimit) begin
        r.sat = 1'b1;
        wide  = NegLimit;
      end
      r.value = -wide[ValueW-1:0];
    end else begin
      if (wide > PosLimit) begin
        r.sat = 1'b1;
        wide  = PosLimit;
      end
      r.value = wide[ValueW-1:0];
    end
    r.count = cnt[CountW-1:0];
    return r;
  endfunction

  // register writes and accepted beats feed the predictor
  always @(posedge clk_i) begin : predict
    voxel_t v;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegThreshold: thr_q = cfg_wdata_i;
          RegWeight:    weight_q = cfg_wdata_i;
          RegLimitSide: upper_q = cfg_wdata_i[0];
          RegQuantity:  qty_q = cfg_wdata_i[1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        v.dose      = s_axis_tdata[15:0];
        v.coeff_one = s_axis_tdata[31:16];
        v.coeff_two = s_axis_tdata[47:32];
        v.last      = s_axis_tlast;
        // beats past the set limit are dropped, but tlast still closes the set
        if (acc_count < DefMaxItems) begin
          acc_sum   = acc_sum + voxel_term(v);
          acc_count = acc_count + 1;
        end
        if (v.last) begin
          expected_penalty_q.push_back(scaled_penalty(acc_sum, acc_count));
          acc_sum   = '0;
          acc_count = 0;
        end
        voxels_taken = voxels_taken + 1;
      end
    end
  end

  always @(posedge clk_i) begin : send
    voxel_t beat;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (voxel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        beat = voxel_q.pop_front();
        s_axis_tdata  <= {beat.coeff_two, beat.coeff_one, beat.dose};
        s_axis_tlast  <= beat.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      hold_left     <= LongHold;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check
    penalty_t got;
    penalty_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata[ValueW-1:0];
      got.count = m_axis_tdata[ValueW+CountW-1:ValueW];
      got.sat   = m_axis_tuser;
      if (expected_penalty_q.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count < 100)
          $display("%0t: unexpected beat: expected none, got value %h sat %b count %0d",
                   $time, got.value, got.sat, got.count);
      end else begin
        want = expected_penalty_q.pop_front();
        if (got.value !== want.value) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count < 100)
            $display("%0t: value mismatch: expected %h, got %h", $time, want.value, got.value);
        end
        if (got.sat !== want.sat) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count < 100)
            $display("%0t: saturated mismatch: expected %b, got %b", $time, want.sat, got.sat);
        end
        if (got.count !== want.count) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count < 100)
            $display("%0t: item_count mismatch: expected %0d, got %0d",
                     $time, want.count, got.count);
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SampleW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic add_voxel(logic [15:0] dose, logic [15:0] c1, logic [15:0] c2, logic last);
    voxel_t v;
    v.dose      = dose;
    v.coeff_one = c1;
    v.coeff_two = c2;
    v.last      = last;
    voxel_q.push_back(v);
    voxels_queued = voxels_queued + 1;
  endtask

  // sender pauses until every beat is taken and every result is back;
  // an open set may still be in the pipe, so let the latency pass too
  task automatic drain();
    while (voxels_taken != voxels_queued) @(posedge clk_i);
    @(posedge clk_i);
    while (expected_penalty_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick16();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin : stimulus
    logic [15:0] cur_thr;
    logic [15:0] dose;
    int          left;
    int          len;
    bit          open_end;
    int unsigned r;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: lower limit at zero, so nothing is penalised
    add_voxel(16'h1234, 16'hFFFF, 16'hFFFF, 1'b1);
    drain();

    // each quantity code on each side, threshold and weight stepped through extreme and middle values
    for (int i = 0; i < 8; i++) begin
      cur_thr = (i % 3 == 0) ? 16'h0000 : (i % 3 == 1) ? 16'h8000 : 16'hFFFF;
      write_reg(RegQuantity, {14'd0, 2'(i >> 1)});
      write_reg(RegLimitSide, {15'd0, 1'(i)});
      write_reg(RegThreshold, cur_thr);
      write_reg(RegWeight, (i % 4 == 0) ? 16'hFFFF : (i % 4 == 1) ? 16'h0000 :
                           (i % 4 == 2) ? WeightReset : 16'h00A5);
      add_voxel(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
      add_voxel(16'hFFFF, 16'hFFFF, 16'h8000, 1'b0);
      add_voxel(cur_thr, 16'h0001, 16'hFFFF, 1'b1);
      drain();
    end

    // random sets; some phases stop mid set so the next register write
    // lands inside an open set
    for (int p = 0; p < 16; p++) begin
      send_idle_pct  = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 76 : 37) : 0;
      recv_stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 2) ? 76 : 37) : 0;
      if (p == 0 || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 3);
        cur_thr = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        write_reg(RegThreshold, cur_thr);
      end
      if (p == 0 || $urandom_range(0, 1)) write_reg(RegWeight, pick16());
      if (p == 0 || $urandom_range(0, 1)) write_reg(RegLimitSide, 16'($urandom_range(0, 1)));
      if (p == 0 || $urandom_range(0, 1)) write_reg(RegQuantity, 16'($urandom_range(0, 3)));
      if (p == 4) hold_req = hold_req + 1;
      open_end = ($urandom_range(0, 2) == 0);
      left = 46;
      while (left > 0) begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 9);
        if (len > left) len = left;
        for (int j = 0; j < len; j++) begin
          r = $urandom_range(0, 5);
          if (r < 2) dose = 16'(int'(cur_thr) + $urandom_range(0, 4) - 2);
          else if (r == 2) dose = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          else dose = 16'($urandom_range(0, 65535));
          add_voxel(dose, pick16(), pick16(),
                    (j == len - 1) && !(open_end && left == len));
        end
        left = left - len;
      end
      drain();
    end

    // spare quantity code under the upper limit
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(RegQuantity, QtySpare);
    write_reg(RegLimitSide, 16'd1);
    write_reg(RegThreshold, 16'h0100);
    for (int k = 0; k < SpareSet; k++)
      add_voxel(16'($urandom_range(0, 65535)), pick16(), pick16(), k == SpareSet - 1);
    drain();

    // a short Hessian set under the upper limit to close
    write_reg(RegQuantity, QtyHess);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    for (int k = 0; k < 6; k++)
      add_voxel(pick16(), pick16(), pick16(), k == 5);
    drain();

    if (mismatch_count == 0) begin
      $display("one_sided_quadratic_penalty regression: pass");
    end else begin
      $display("one_sided_quadratic_penalty regression: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("one_sided_quadratic_penalty regression: fail");
    $finish;
  end

endmodule

[one_sided_quadratic_penalty.f]
hw/rtl/ospq_pkg.sv
hw/rtl/ospq_ctrl.sv
hw/rtl/ospq_dp.sv
hw/rtl/one_sided_quadratic_penalty.sv
tb/sv/tb_one_sided_quadratic_penalty.sv
